FILE: sv/gha_pkg.sv
// Shared constants and codes for the generational handle allocator.
// Depends on nothing; the allocator top level imports it.
package gha_pkg;

    // Table geometry.
    localparam int SLOT_COUNT = 256;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);
    localparam int GEN_W      = 32;
    localparam int HIDX_W     = 32;
    localparam int OIDX_W     = 8;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_BITS    = 2 + HIDX_W + GEN_W;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 2 + OIDX_W + GEN_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Command codes.
    localparam logic [1:0] CMD_ALLOC    = 2'd0;
    localparam logic [1:0] CMD_RELEASE  = 2'd1;
    localparam logic [1:0] CMD_VALIDATE = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

endpackage

FILE: sv/gha_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the generation table and the free stack.
module gha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds while not enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/generational_handle_allocator.sv
// Generational handle allocator: top level with its control sequencer.
// Depends on gha_pkg and on gha_ram for the generation table and free stack.
//
// Usage
// The slave stream (i_s_tvalid / o_s_tready / i_s_tdata) carries one command:
// allocate, release by handle, or validate a handle. The master stream
// (o_m_tvalid / i_m_tready / o_m_tdata) returns exactly one result per command:
// a status, the slot index and the slot's generation after the operation.
// The result is registered from the execute step that follows the input
// transfer, with a pop step before it for an allocate that pops the free
// stack: the stack read and the generation read are two dependent registered
// memory reads. One command is in flight at a time, so a new command is
// taken only after the previous one has left the execute step.
// The result sits in an output register; the next command is accepted while
// it waits. If the receiver stalls, the sequencer holds its finished command
// in the execute step until the output register is free.
// A synchronous reset clears the fill counters, the per-slot valid bits of
// the generation table (an unwritten slot reads as generation zero) and the
// handshake state; no clearing pass runs, so commands are taken at once.
module generational_handle_allocator
    import gha_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Command stream. tdata: cmd[1:0], handle_index[33:2],
    // handle_generation[65:34], zero padding above.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // Result stream. tdata: status[1:0], slot_index[9:2],
    // slot_generation[41:10], zero padding above.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_EXEC
    } t_state;

    t_state                r_state,       n_state;
    logic [1:0]            r_cmd,         n_cmd;
    logic [HIDX_W-1:0]     r_idx,         n_idx;
    logic [GEN_W-1:0]      r_gen,         n_gen;
    logic [SLOT_W-1:0]     r_slot,        n_slot;
    logic                  r_popped,      n_popped;
    logic [COUNT_W-1:0]    r_free_count,  n_free_count;
    logic [COUNT_W-1:0]    r_next_unused, n_next_unused;
    logic [SLOT_COUNT-1:0] r_gen_valid,   n_gen_valid;
    logic                  r_out_valid,   n_out_valid;
    logic [1:0]            r_status,      n_status;
    logic [OIDX_W-1:0]     r_out_idx,     n_out_idx;
    logic [GEN_W-1:0]      r_out_gen,     n_out_gen;

    // Memory ports.
    logic                  gen_we, gen_re, stk_we, stk_re;
    logic [SLOT_W-1:0]     gen_waddr, gen_raddr, stk_waddr, stk_raddr;
    logic [GEN_W-1:0]      gen_wdata, gen_rdata;
    logic [SLOT_W-1:0]     stk_rdata;

    logic                  in_xfer, out_free;
    logic [COUNT_W-1:0]    cnt_m1;
    logic [GEN_W-1:0]      cur_gen, inc_gen;
    logic                  handle_good;
    logic [HIDX_W-1:0]     slot_ext, unused_ext;

    gha_ram #(.WIDTH(GEN_W), .DEPTH(SLOT_COUNT)) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (gen_we),
        .i_waddr (gen_waddr),
        .i_wdata (gen_wdata),
        .i_re    (gen_re),
        .i_raddr (gen_raddr),
        .o_rdata (gen_rdata)
    );

    gha_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (r_slot),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign in_xfer    = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;
    assign cnt_m1     = r_free_count - 1'b1;

    // An unwritten slot reads as generation zero.
    assign cur_gen     = r_gen_valid[r_slot] ? gen_rdata : '0;
    assign inc_gen     = cur_gen + 1'b1;
    assign handle_good = (r_idx < HIDX_W'(SLOT_COUNT)) && (cur_gen == r_gen);
    assign slot_ext    = HIDX_W'(r_slot);
    assign unused_ext  = HIDX_W'(r_next_unused);

    // Read addresses: top of stack and handle slot at accept, popped slot next.
    always_comb begin
        stk_re    = in_xfer && (i_s_tdata[1:0] == CMD_ALLOC) && (r_free_count != '0);
        stk_raddr = cnt_m1[SLOT_W-1:0];
        gen_re    = in_xfer || (r_state == S_POP);
        gen_raddr = (r_state == S_POP) ? stk_rdata : i_s_tdata[2 +: SLOT_W];
    end

    // Sequencer and read-modify-write of the tables.
    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_idx         = r_idx;
        n_gen         = r_gen;
        n_slot        = r_slot;
        n_popped      = r_popped;
        n_free_count  = r_free_count;
        n_next_unused = r_next_unused;
        n_gen_valid   = r_gen_valid;
        n_out_valid   = r_out_valid && !i_m_tready;
        n_status      = r_status;
        n_out_idx     = r_out_idx;
        n_out_gen     = r_out_gen;
        gen_we        = 1'b0;
        gen_waddr     = r_slot;
        gen_wdata     = inc_gen;
        stk_we        = 1'b0;
        stk_waddr     = r_free_count[SLOT_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd    = i_s_tdata[1:0];
                    n_idx    = i_s_tdata[2 +: HIDX_W];
                    n_gen    = i_s_tdata[2 + HIDX_W +: GEN_W];
                    n_slot   = i_s_tdata[2 +: SLOT_W];
                    n_popped = stk_re;
                    n_state  = stk_re ? S_POP : S_EXEC;
                end
            end
            S_POP: begin
                n_slot       = stk_rdata;
                n_free_count = cnt_m1;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_status    = ST_BAD;
                    n_out_idx   = '0;
                    n_out_gen   = '0;
                    priority if (r_cmd == CMD_ALLOC) begin
                        priority if (r_popped) begin
                            n_status  = ST_OK;
                            n_out_idx = slot_ext[OIDX_W-1:0];
                            n_out_gen = cur_gen;
                        end else if (r_next_unused < COUNT_W'(SLOT_COUNT)) begin
                            gen_we        = 1'b1;
                            gen_waddr     = r_next_unused[SLOT_W-1:0];
                            gen_wdata     = GEN_W'(1);
                            n_gen_valid[r_next_unused[SLOT_W-1:0]] = 1'b1;
                            n_next_unused = r_next_unused + 1'b1;
                            n_status      = ST_OK;
                            n_out_idx     = unused_ext[OIDX_W-1:0];
                            n_out_gen     = GEN_W'(1);
                        end else begin
                            n_status = ST_FULL;
                        end
                    end else if (r_cmd == CMD_RELEASE && handle_good) begin
                        gen_we              = 1'b1;
                        n_gen_valid[r_slot] = 1'b1;
                        if (r_free_count < COUNT_W'(SLOT_COUNT)) begin
                            stk_we       = 1'b1;
                            n_free_count = r_free_count + 1'b1;
                        end
                        n_status  = ST_OK;
                        n_out_idx = r_idx[OIDX_W-1:0];
                        n_out_gen = inc_gen;
                    end else if (r_cmd == CMD_VALIDATE && handle_good) begin
                        n_status  = ST_OK;
                        n_out_idx = r_idx[OIDX_W-1:0];
                        n_out_gen = cur_gen;
                    end else begin
                        // Bad handle or unknown command: nothing changes.
                        n_status = ST_BAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State, counters and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_free_count  <= '0;
            r_next_unused <= '0;
            r_gen_valid   <= '0;
            r_out_valid   <= 1'b0;
            r_popped      <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_free_count  <= n_free_count;
            r_next_unused <= n_next_unused;
            r_gen_valid   <= n_gen_valid;
            r_out_valid   <= n_out_valid;
            r_popped      <= n_popped;
        end
        r_cmd     <= n_cmd;
        r_idx     <= n_idx;
        r_gen     <= n_gen;
        r_slot    <= n_slot;
        r_status  <= n_status;
        r_out_idx <= n_out_idx;
        r_out_gen <= n_out_gen;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_out_gen, r_out_idx, r_status});

    // The fill counters never pass the table size.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= COUNT_W'(SLOT_COUNT))
        else $error("free stack count above table size");

    a_unused_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_unused <= COUNT_W'(SLOT_COUNT))
        else $error("never-used pointer above table size");

    // A pop is only started with a non-empty stack.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_free_count != '0))
        else $error("pop from an empty free stack");

    // Tables are written only when a result is produced.
    a_write_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (gen_we || stk_we) |=> r_out_valid)
        else $error("table write without a result");

endmodule

FILE: tb/handle_result_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the generational handle allocator: watches both streams,
// predicts each result from a private copy of the slot table and compares.
// Depends on gha_pkg for widths and codes.
module handle_result_checker
    import gha_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Command stream. tdata: cmd, handle_index, handle_generation, padding.
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // Result stream. tdata: status, slot_index, slot_generation, padding.
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic [1:0]        status;
        logic [OIDX_W-1:0] slot;
        logic [GEN_W-1:0]  gen;
    } t_slot_result;

    // Private copy of the allocator state.
    logic [GEN_W-1:0]   gen_table  [SLOT_COUNT];
    logic [SLOT_W-1:0]  free_stack [SLOT_COUNT];
    logic [COUNT_W-1:0] free_count;
    logic [COUNT_W-1:0] next_unused;

    t_slot_result expected_results[$];

    // Applies one command to the private table and returns its result.
    function automatic t_slot_result execute_command(logic [1:0] cmd,
                                                     logic [HIDX_W-1:0] idx,
                                                     logic [GEN_W-1:0] gen);
        t_slot_result      res;
        logic [SLOT_W-1:0] slot;
        res  = '{ST_BAD, '0, '0};
        slot = idx[SLOT_W-1:0];
        case (cmd)
            CMD_ALLOC: begin
                if (free_count > 0) begin
                    free_count = free_count - 1'b1;
                    slot       = free_stack[free_count[SLOT_W-1:0]];
                    res        = '{ST_OK, OIDX_W'(slot), gen_table[slot]};
                end else if (next_unused < SLOT_COUNT) begin
                    slot            = next_unused[SLOT_W-1:0];
                    gen_table[slot] = 1;
                    next_unused     = next_unused + 1'b1;
                    res             = '{ST_OK, OIDX_W'(slot), gen_table[slot]};
                end else begin
                    res = '{ST_FULL, '0, '0};
                end
            end
            CMD_RELEASE, CMD_VALIDATE: begin
                if (idx < SLOT_COUNT && gen_table[slot] == gen) begin
                    if (cmd == CMD_RELEASE) begin
                        gen_table[slot] = gen_table[slot] + 1'b1;
                        // The stack saturates: a push onto a full stack is lost.
                        if (free_count < SLOT_COUNT) begin
                            free_stack[free_count[SLOT_W-1:0]] = slot;
                            free_count = free_count + 1'b1;
                        end
                    end
                    res = '{ST_OK, OIDX_W'(slot), gen_table[slot]};
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Predict on every command transfer, compare on every result transfer.
    always @(posedge i_clk) begin
        t_slot_result want;
        t_slot_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) gen_table[i] = '0;
            free_count   = '0;
            next_unused  = '0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(execute_command(i_s_tdata[1:0],
                                                           i_s_tdata[33:2],
                                                           i_s_tdata[65:34]));
            if (i_m_tvalid && i_m_tready) begin
                got = '{i_m_tdata[1:0], i_m_tdata[9:2], i_m_tdata[41:10]};
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d slot %0d generation %0h",
                           got.status, got.slot, got.gen);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.slot !== want.slot) begin
                        $error("slot_index mismatch: expected %0d, actual %0d",
                               want.slot, got.slot);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (got.gen !== want.gen) begin
                        $error("slot_generation mismatch: expected %0h, actual %0h",
                               want.gen, got.gen);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the allocator testbench: clock, reset, command stimulus, result
// back-pressure and verdict. Depends on gha_pkg, handle_result_checker and the DUT.
module testbench;
    import gha_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    int fail_count;
    int pending;

    // Idling percentages of the current phase.
    int snd_idle_pct = 27;
    int rcv_idle_pct = 47;

    // Handles seen in results, used to aim commands at live slots.
    logic [GEN_W-1:0] last_gen  [SLOT_COUNT];
    bit               seen_slot [SLOT_COUNT];
    bit               full_seen = 1'b0;

    int cmds_sent  = 0;
    int n_ok       = 0;
    int n_full     = 0;
    int n_bad      = 0;
    int idle_count = 0;
    int failures;

    generational_handle_allocator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    handle_result_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Clock with a 4 ns period.
    always #2 i_clk = ~i_clk;

    // Random back-pressure on the result stream.
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Track returned handles and watch for a stalled run.
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            case (o_m_tdata[1:0])
                ST_OK: begin
                    n_ok++;
                    seen_slot[o_m_tdata[9:2]] = 1'b1;
                    last_gen[o_m_tdata[9:2]]  = o_m_tdata[41:10];
                end
                ST_FULL: begin
                    n_full++;
                    full_seen = 1'b1;
                end
                default: n_bad++;
            endcase
        end
        if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offers one command and returns once its transfer has happened.
    task automatic send_command(logic [1:0] cmd, logic [HIDX_W-1:0] idx,
                                logic [GEN_W-1:0] gen);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_DATA_W'({gen, idx, cmd});
        do @(posedge i_clk); while (!o_s_tready);
        cmds_sent++;
    endtask

    // Drops valid and waits for every outstanding result.
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic set_idling(int snd_pct, int rcv_pct);
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
    endtask

    // Mostly well-formed traffic against known handles, with some noise.
    task automatic send_random_command();
        int               pick;
        int               slot;
        logic [GEN_W-1:0] gen;
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, SLOT_COUNT - 1);
        gen  = seen_slot[slot] ? last_gen[slot] : '0;
        // Now and then use a stale or future generation.
        if ($urandom_range(0, 7) == 0) gen = gen - 1'b1;
        else if ($urandom_range(0, 15) == 0) gen = gen + 1'b1;
        if (pick < 30)
            send_command(CMD_ALLOC, $urandom(), $urandom());
        else if (pick < 55)
            send_command(CMD_RELEASE, HIDX_W'(slot), gen);
        else if (pick < 85)
            send_command(CMD_VALIDATE, HIDX_W'(slot), gen);
        else if (pick < 92)
            send_command(2'($urandom_range(0, 3)), $urandom(), $urandom());
        else
            send_command(2'($urandom_range(1, 2)),
                         HIDX_W'($urandom_range(SLOT_COUNT, SLOT_COUNT + 3)), gen);
    endtask

    // Short directed sequence from reset: basic flow and the corner cases.
    task automatic run_directed_commands();
        send_command(CMD_ALLOC, '0, '0);                      // slot 0, gen 1
        send_command(CMD_ALLOC, '0, '0);                      // slot 1, gen 1
        send_command(CMD_VALIDATE, 32'd0, 32'd1);
        send_command(CMD_VALIDATE, 32'd0, 32'd2);             // wrong generation
        send_command(CMD_RELEASE, 32'd0, 32'd1);
        send_command(CMD_VALIDATE, 32'd0, 32'd1);             // stale handle
        send_command(CMD_RELEASE, 32'd0, 32'd1);              // double release
        send_command(CMD_ALLOC, '0, '0);                      // pops slot 0
        // A never-used slot holds generation zero.
        send_command(CMD_VALIDATE, 32'd200, 32'd0);
        send_command(CMD_RELEASE, 32'd201, 32'd0);
        send_command(CMD_ALLOC, '0, '0);                      // pops slot 201
        // Index range edges.
        send_command(CMD_VALIDATE, HIDX_W'(SLOT_COUNT), 32'd0);
        send_command(CMD_VALIDATE, HIDX_W'(SLOT_COUNT - 1), 32'd0);
        send_command(CMD_RELEASE, 32'hffff_ffff, 32'hffff_ffff);
        send_command(CMD_VALIDATE, 32'd1, 32'hffff_ffff);
        // Unknown command, with plain and all-ones fields.
        send_command(CMD_UNKNOWN, 32'd0, 32'd1);
        send_command(CMD_UNKNOWN, 32'hffff_ffff, 32'hffff_ffff);
        // Allocate ignores its handle fields.
        send_command(CMD_ALLOC, 32'hffff_ffff, 32'hffff_ffff);
        send_command(CMD_RELEASE, 32'd1, 32'd1);
        send_command(CMD_RELEASE, 32'd2, 32'd1);
        send_command(CMD_ALLOC, '0, '0);
        send_command(CMD_ALLOC, '0, '0);
        wait_idle();
    endtask

    // Allocate until the table reports full, release every slot, then release
    // a few more so that pushes hit the saturated free stack.
    task automatic run_capacity_sweep();
        int batches;
        batches = 0;
        while (!full_seen && batches < 40) begin
            repeat (16) send_command(CMD_ALLOC, $urandom(), $urandom());
            wait_idle();
            batches++;
        end
        for (int s = 0; s < SLOT_COUNT; s++)
            send_command(CMD_RELEASE, HIDX_W'(s), last_gen[s]);
        wait_idle();
        repeat (8) begin
            int s;
            s = $urandom_range(0, SLOT_COUNT - 1);
            send_command(CMD_RELEASE, HIDX_W'(s), last_gen[s]);
            wait_idle();
        end
    endtask

    // Stimulus and verdict.
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(27, 47);
        run_directed_commands();
        repeat (300) send_random_command();
        wait_idle();

        set_idling(47, 27);
        run_capacity_sweep();
        repeat (100) send_random_command();
        wait_idle();

        set_idling(0, 0);
        repeat (280) send_random_command();
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        failures = fail_count;
        if (pending != 0) begin
            $error("%0d expected results never arrived", pending);
            failures = failures + 1;
        end
        $display("Summary: %0d commands sent; results ok %0d, table full %0d, invalid %0d.",
                 cmds_sent, n_ok, n_full, n_bad);
        $display("Covered three idling patterns, a full table and a saturated free stack.");
        if (failures == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/gha_pkg.sv
sv/gha_ram.sv
sv/generational_handle_allocator.sv
tb/handle_result_checker.sv
tb/testbench.sv
